>>> rtl/h4rx_pkg.sv
// ----------------------------------------------------------------------------
// h4rx_pkg
// Shared types and constants for the H4 UART receive deframer.
// ----------------------------------------------------------------------------
package h4rx_pkg;

    localparam logic [7:0] TYPE_EVENT = 8'h04;
    localparam logic [7:0] TYPE_ACL   = 8'h02;

    localparam logic [2:0] HLEN_EVENT = 3'd2;
    localparam logic [2:0] HLEN_ACL   = 3'd4;

    localparam logic [15:0] EVENT_ROOM_RST = 16'd255;
    localparam logic [15:0] ACL_ROOM_RST   = 16'd1024;

    typedef enum logic [0:0] {
        CFG_EVENT_ROOM = 1'b0,
        CFG_ACL_ROOM   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_DELIVER = 3'd0,
        ST_HELD    = 3'd1,
        ST_DISCARD = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_NOBUF   = 3'd4,
        ST_TOOLONG = 3'd5
    } t_status;

    // One queue entry: either a single result or a header replay.
    typedef struct packed {
        logic            replay;
        logic            kind;
        t_status         status;
        logic            last;
        logic            zero_len;
        logic [7:0]      data;
        logic [3:0][7:0] hdr;
    } t_cmd;

endpackage

>>> rtl/h4rx_front.sv
// ----------------------------------------------------------------------------
// h4rx_front
// Byte classifier: tracks the H4 framing state and turns each received byte
// into one queue command.
// ----------------------------------------------------------------------------
module h4rx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_push_ok,
    input  logic [7:0]          i_byte,
    input  logic                i_bfree,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata,
    output logic                o_push,
    output h4rx_pkg::t_cmd      o_cmd
);

    h4rx_pkg::t_phase r_phase, n_phase;
    logic             r_kind, n_kind;
    logic [3:0][7:0]  r_hdr, n_hdr;
    logic [2:0]       r_count, n_count;
    logic [15:0]      r_rem, n_rem;
    logic             r_drop, n_drop;
    logic [7:0]       r_event_room;
    logic [15:0]      r_acl_room;

    logic [3:0][7:0]  w_hdr;
    logic [2:0]       w_count;
    logic [2:0]       w_hlen;
    logic             w_hdone;
    logic [15:0]      w_len;
    logic [15:0]      w_room;
    logic             w_reject;
    logic [15:0]      w_rem_dec;
    logic             w_is_type;
    logic             w_fire;

    assign w_fire    = i_valid & i_push_ok;
    assign o_push    = w_fire;

    always_comb begin
        w_hdr                = r_hdr;
        w_hdr[r_count[1:0]]  = i_byte;
    end

    assign w_count   = r_count + 3'd1;
    assign w_hlen    = r_kind ? h4rx_pkg::HLEN_ACL : h4rx_pkg::HLEN_EVENT;
    assign w_hdone   = !(w_count < w_hlen);
    assign w_len     = r_kind ? {w_hdr[3], w_hdr[2]} : {8'd0, w_hdr[1]};
    assign w_room    = r_kind ? r_acl_room : {8'd0, r_event_room};
    assign w_reject  = !i_bfree || (w_len > w_room);
    assign w_rem_dec = r_rem - 16'd1;
    assign w_is_type = (i_byte == h4rx_pkg::TYPE_EVENT) || (i_byte == h4rx_pkg::TYPE_ACL);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_hdr   = r_hdr;
        n_count = r_count;
        n_rem   = r_rem;
        n_drop  = r_drop;
        case (r_phase)
            h4rx_pkg::PH_HEADER: begin
                n_hdr   = w_hdr;
                n_count = w_count;
                if (w_hdone) begin
                    n_count = 3'd0;
                    n_rem   = w_len;
                    n_drop  = w_reject;
                    n_phase = (w_len != 16'd0) ? h4rx_pkg::PH_PAYLOAD : h4rx_pkg::PH_IDLE;
                end
            end
            h4rx_pkg::PH_PAYLOAD: begin
                n_rem = w_rem_dec;
                if (w_rem_dec == 16'd0) begin
                    n_phase = h4rx_pkg::PH_IDLE;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_phase = h4rx_pkg::PH_IDLE;
                if (w_is_type) begin
                    n_kind  = (i_byte == h4rx_pkg::TYPE_ACL);
                    n_count = 3'd0;
                    n_phase = h4rx_pkg::PH_HEADER;
                end
            end
        endcase
    end

    // command output
    always_comb begin
        o_cmd          = '0;
        o_cmd.hdr      = w_hdr;
        o_cmd.kind     = r_kind;
        o_cmd.status   = h4rx_pkg::ST_HELD;
        case (r_phase)
            h4rx_pkg::PH_HEADER: begin
                if (!w_hdone) begin
                    o_cmd.status = h4rx_pkg::ST_HELD;
                end else if (w_reject) begin
                    o_cmd.status = i_bfree ? h4rx_pkg::ST_TOOLONG : h4rx_pkg::ST_NOBUF;
                end else begin
                    o_cmd.replay   = 1'b1;
                    o_cmd.status   = h4rx_pkg::ST_DELIVER;
                    o_cmd.zero_len = (w_len == 16'd0);
                end
            end
            h4rx_pkg::PH_PAYLOAD: begin
                if (r_drop) begin
                    o_cmd.status = h4rx_pkg::ST_DISCARD;
                end else begin
                    o_cmd.status = h4rx_pkg::ST_DELIVER;
                    o_cmd.data   = i_byte;
                    o_cmd.last   = (w_rem_dec == 16'd0);
                end
            end
            default: begin
                if (w_is_type) begin
                    o_cmd.kind   = (i_byte == h4rx_pkg::TYPE_ACL);
                    o_cmd.status = h4rx_pkg::ST_HELD;
                end else begin
                    o_cmd.kind   = 1'b0;
                    o_cmd.status = h4rx_pkg::ST_UNKNOWN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= h4rx_pkg::PH_IDLE;
            r_kind  <= 1'b0;
            r_count <= 3'd0;
            r_rem   <= 16'd0;
            r_drop  <= 1'b0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_room <= h4rx_pkg::EVENT_ROOM_RST[7:0];
            r_acl_room   <= h4rx_pkg::ACL_ROOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                h4rx_pkg::CFG_EVENT_ROOM: r_event_room <= i_cfg_wdata[7:0];
                h4rx_pkg::CFG_ACL_ROOM:   r_acl_room   <= i_cfg_wdata;
                default:                  r_acl_room   <= r_acl_room;
            endcase
        end
    end

endmodule

>>> rtl/h4rx_queue.sv
// ----------------------------------------------------------------------------
// h4rx_queue
// Small command FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module h4rx_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  h4rx_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output h4rx_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    h4rx_pkg::t_cmd r_mem [P_DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           w_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/h4rx_back.sv
// ----------------------------------------------------------------------------
// h4rx_back
// Output sequencer: drains queue commands into the output register and
// replays held header bytes one transfer at a time.
// ----------------------------------------------------------------------------
module h4rx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  h4rx_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_kind,
    output logic [2:0]      o_status,
    output logic            o_last
);

    logic            r_valid;
    logic [7:0]      r_data;
    logic            r_kind;
    h4rx_pkg::t_status r_status;
    logic            r_last;
    logic [1:0]      r_idx;

    logic            w_load;
    logic [1:0]      w_hlast;
    logic            w_final;

    assign w_load  = !r_valid || i_ready;
    assign w_hlast = i_q_cmd.kind ? 2'd3 : 2'd1;
    assign w_final = (r_idx == w_hlast);
    assign o_q_pop = w_load && i_q_valid && (!i_q_cmd.replay || w_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid && i_q_cmd.replay) begin
                r_idx <= w_final ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_kind   <= i_q_cmd.kind;
            r_status <= i_q_cmd.status;
            if (i_q_cmd.replay) begin
                r_data <= i_q_cmd.hdr[r_idx];
                r_last <= i_q_cmd.zero_len && w_final;
            end else begin
                r_data <= i_q_cmd.data;
                r_last <= i_q_cmd.last;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_kind   = r_kind;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

>>> rtl/hci_uart_h4_rx_deframer.sv
// ----------------------------------------------------------------------------
// hci_uart_h4_rx_deframer
// Each input byte goes through the command queue, then the output register.
// Throughput: one input byte per cycle; an accepted header gives 2 (event)
// or 4 (ACL) output transfers from one queue entry, so input backs up into
// the command queue during that replay and stalls only when the queue fills.
// Reset: framing state cleared to idle, queue emptied, rooms 255 and 1024.
// ----------------------------------------------------------------------------
module hci_uart_h4_rx_deframer #(
    parameter int P_QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] buffer_free
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]  m_axis_tuser,   // [0] packet_kind, [3:1] status
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic           w_push;
    logic           w_q_ready;
    logic           w_q_valid;
    logic           w_q_pop;
    h4rx_pkg::t_cmd w_front_cmd;
    h4rx_pkg::t_cmd w_q_cmd;
    logic [2:0]     w_status;
    logic           w_kind;

    assign s_axis_tready = w_q_ready;

    h4rx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_push_ok   (w_q_ready),
        .i_byte      (s_axis_tdata[7:0]),
        .i_bfree     (s_axis_tdata[8]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    h4rx_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    h4rx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_kind    (w_kind),
        .o_status  (w_status),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = {w_status, w_kind};

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status <= h4rx_pkg::ST_TOOLONG))
        else $error("status code out of range");

    a_nondeliver_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status != h4rx_pkg::ST_DELIVER))
            |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))
        else $error("non-delivered result carries data or last");

    a_unknown_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == h4rx_pkg::ST_UNKNOWN)) |-> !w_kind)
        else $error("unknown type reported with ACL kind");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue pop while empty");

endmodule

>>> tb/h4rx_checker.sv
// ----------------------------------------------------------------------------
// h4rx_checker
// Watches the byte stream into the H4 receive deframer, the deframed
// stream out of it and the room register writes. Keeps its own copy of the
// framing state, queues the results each accepted byte should give and
// compares every output transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module h4rx_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,     // [7:0] rx_byte, [8] buffer_free
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,     // [7:0] out_byte
    input  logic [3:0]  i_m_tuser,     // [0] packet_kind, [3:1] status
    input  logic        i_m_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output logic [1:0]  o_framing
);

    typedef struct {
        logic [7:0]        data;
        logic              kind;
        h4rx_pkg::t_status status;
        logic              fin;
    } t_h4_result;

    t_h4_result       pending_results[$];

    logic [7:0]       ev_room;
    logic [15:0]      acl_room;
    h4rx_pkg::t_phase framing;
    logic             pkt_kind;
    logic [3:0][7:0]  hdr_bytes;
    logic [2:0]       hdr_cnt;
    logic [15:0]      payload_left;
    logic             discarding;

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        o_errors++;
    endtask

    task automatic queue_result(input logic [7:0] data, input logic kind,
                                input h4rx_pkg::t_status status, input logic fin);
        t_h4_result r;
        r.data   = data;
        r.kind   = kind;
        r.status = status;
        r.fin    = fin;
        pending_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic buf_free);
        logic [2:0]  hlen;
        logic [15:0] len;
        logic [15:0] room;
        case (framing)
            h4rx_pkg::PH_HEADER: begin
                hlen = pkt_kind ? h4rx_pkg::HLEN_ACL : h4rx_pkg::HLEN_EVENT;
                hdr_bytes[hdr_cnt[1:0]] = b;
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt < hlen) begin
                    queue_result(8'h00, pkt_kind, h4rx_pkg::ST_HELD, 1'b0);
                end else begin
                    len  = pkt_kind ? {hdr_bytes[3], hdr_bytes[2]} : {8'h00, hdr_bytes[1]};
                    room = pkt_kind ? acl_room : {8'h00, ev_room};
                    hdr_cnt = 3'd0;
                    payload_left = len;
                    if (!buf_free || len > room) begin
                        queue_result(8'h00, pkt_kind,
                                     buf_free ? h4rx_pkg::ST_TOOLONG : h4rx_pkg::ST_NOBUF,
                                     1'b0);
                        discarding = 1'b1;
                    end else begin
                        for (int i = 0; i < hlen; i++)
                            queue_result(hdr_bytes[i], pkt_kind, h4rx_pkg::ST_DELIVER,
                                         (i == hlen - 1) && (len == 16'd0));
                        discarding = 1'b0;
                    end
                    framing = (len != 16'd0) ? h4rx_pkg::PH_PAYLOAD : h4rx_pkg::PH_IDLE;
                end
            end
            h4rx_pkg::PH_PAYLOAD: begin
                payload_left = payload_left - 16'd1;
                if (discarding)
                    queue_result(8'h00, pkt_kind, h4rx_pkg::ST_DISCARD, 1'b0);
                else
                    queue_result(b, pkt_kind, h4rx_pkg::ST_DELIVER, payload_left == 16'd0);
                if (payload_left == 16'd0) begin
                    framing = h4rx_pkg::PH_IDLE;
                    discarding = 1'b0;
                end
            end
            default: begin
                framing = h4rx_pkg::PH_IDLE;
                if (b == h4rx_pkg::TYPE_EVENT || b == h4rx_pkg::TYPE_ACL) begin
                    pkt_kind = (b == h4rx_pkg::TYPE_ACL);
                    hdr_cnt = 3'd0;
                    framing = h4rx_pkg::PH_HEADER;
                    queue_result(8'h00, pkt_kind, h4rx_pkg::ST_HELD, 1'b0);
                end else begin
                    queue_result(8'h00, 1'b0, h4rx_pkg::ST_UNKNOWN, 1'b0);
                end
            end
        endcase
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_framing = h4rx_pkg::PH_IDLE;
    end

    always @(posedge i_clk) begin
        t_h4_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            ev_room      = h4rx_pkg::EVENT_ROOM_RST[7:0];
            acl_room     = h4rx_pkg::ACL_ROOM_RST;
            framing      = h4rx_pkg::PH_IDLE;
            pkt_kind     = 1'b0;
            hdr_bytes    = '0;
            hdr_cnt      = 3'd0;
            payload_left = 16'd0;
            discarding   = 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report("output transfer with nothing expected", i_m_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tdata !== want.data)
                        report("out_byte", i_m_tdata, want.data);
                    if (i_m_tuser[0] !== want.kind)
                        report("packet_kind", i_m_tuser[0], want.kind);
                    if (i_m_tuser[3:1] !== want.status)
                        report("status", i_m_tuser[3:1], want.status);
                    if (i_m_tlast !== want.fin)
                        report("last", i_m_tlast, want.fin);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    h4rx_pkg::CFG_EVENT_ROOM: ev_room  = i_cfg_wdata[7:0];
                    h4rx_pkg::CFG_ACL_ROOM:   acl_room = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                deframe_byte(i_s_tdata[7:0], i_s_tdata[8]);
        end
        o_pending = pending_results.size();
        o_framing = framing;
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives UART bytes into the H4 receive deframer: directed packets for the
// zero-length, no-buffer, too-long and unknown-type cases, then random
// event and ACL packets (some cut short) across several room settings,
// with bursty input, a stalling output side and one long output hold-off.
// A separate checker predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] rx_byte, [8] buffer_free
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic [3:0]  m_axis_tuser;   // [0] packet_kind, [3:1] status
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    int          check_errors;
    int          results_due;
    logic [1:0]  framing;

    int          items_sent;
    int          burst_left;
    bit          no_gaps;
    bit          hold_req;
    logic [7:0]  ev_room_now;
    logic [15:0] acl_room_now;

    hci_uart_h4_rx_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    h4rx_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (check_errors),
        .o_pending   (results_due),
        .o_framing   (framing)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: segments of full, partial and sparse readiness
    initial begin
        int pct;
        m_axis_tready = 1'b0;
        forever begin
            pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 80);
            repeat ($urandom_range(5, 60)) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (120) @(negedge i_clk);
                end else begin
                    m_axis_tready <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic buf_free);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, buf_free, b};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // type byte, header, payload; cut below the full size truncates the packet,
    // after which the framer is walked back to idle
    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] h0,
                               input logic [7:0] h1, input logic [15:0] len,
                               input logic buf_free, input int cut);
        logic [7:0] pkt[$];
        int         hlen;
        int         n;
        bit         first;
        pkt.push_back(ptype);
        if (ptype == h4rx_pkg::TYPE_ACL) begin
            pkt.push_back(h0);
            pkt.push_back(h1);
            pkt.push_back(len[7:0]);
            pkt.push_back(len[15:8]);
            hlen = h4rx_pkg::HLEN_ACL;
        end else begin
            pkt.push_back(h0);
            pkt.push_back(len[7:0]);
            hlen = h4rx_pkg::HLEN_EVENT;
        end
        for (int i = 0; i < len; i++)
            pkt.push_back(8'($urandom));
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], (i == hlen) ? buf_free : 1'($urandom));
        first = 1'b1;
        while (framing != h4rx_pkg::PH_IDLE) begin
            if (framing == h4rx_pkg::PH_HEADER)
                send_byte(8'h00, 1'($urandom));
            else if (first && $urandom_range(0, 1) == 1)
                send_byte(($urandom_range(0, 1) == 1) ? h4rx_pkg::TYPE_ACL
                                                      : h4rx_pkg::TYPE_EVENT, 1'b1);
            else
                send_byte(8'($urandom), 1'($urandom));
            first = 1'b0;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (results_due != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_room(input h4rx_pkg::t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        if (idx == h4rx_pkg::CFG_EVENT_ROOM)
            ev_room_now = value[7:0];
        else
            acl_room_now = value;
    endtask

    task automatic set_rooms(input logic [7:0] ev, input logic [15:0] acl);
        wait_drained();
        write_room(h4rx_pkg::CFG_EVENT_ROOM, {8'h00, ev});
        write_room(h4rx_pkg::CFG_ACL_ROOM, acl);
    endtask

    task automatic random_traffic(input int n_items);
        int          stop_at;
        int          sel;
        int          room;
        int          lim;
        int          len;
        int          total;
        int          cut;
        logic        acl;
        logic [7:0]  v;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) < 3) begin
                do v = 8'($urandom);
                while (v == h4rx_pkg::TYPE_EVENT || v == h4rx_pkg::TYPE_ACL);
                send_byte(v, 1'($urandom));
            end else begin
                acl  = 1'($urandom);
                room = acl ? acl_room_now : ev_room_now;
                lim  = acl ? 65535 : 255;
                sel  = $urandom_range(0, 19);
                if (sel < 2 && room < 20 && room < lim)
                    len = room + 1;
                else if (sel < 4 && room <= 20)
                    len = room;
                else if (sel < 7)
                    len = 0;
                else
                    len = $urandom_range(1, 6);
                total = 1 + (acl ? 4 : 2) + len;
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : 0;
                send_packet(acl ? h4rx_pkg::TYPE_ACL : h4rx_pkg::TYPE_EVENT,
                            8'($urandom), 8'($urandom),
                            16'(len), $urandom_range(0, 7) != 0, cut);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = h4rx_pkg::CFG_EVENT_ROOM;
        i_cfg_wdata   = 16'h0000;
        items_sent    = 0;
        burst_left    = 0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        ev_room_now   = h4rx_pkg::EVENT_ROOM_RST[7:0];
        acl_room_now  = h4rx_pkg::ACL_ROOM_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unknown types, zero-length and short packets, no buffer
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_packet(h4rx_pkg::TYPE_EVENT, 8'h0E, 8'h00, 16'd0, 1'b1, 0);
        send_packet(h4rx_pkg::TYPE_ACL, 8'hFF, 8'hFF, 16'd2, 1'b1, 0);
        send_packet(h4rx_pkg::TYPE_EVENT, 8'h3E, 8'h00, 16'd1, 1'b0, 0);
        send_packet(h4rx_pkg::TYPE_ACL, 8'h00, 8'h00, 16'd0, 1'b0, 0);
        random_traffic(20);

        // no room at all: too long, and no buffer taking precedence
        set_rooms(8'd0, 16'd0);
        send_packet(h4rx_pkg::TYPE_EVENT, 8'h10, 8'h00, 16'd1, 1'b1, 0);
        send_packet(h4rx_pkg::TYPE_EVENT, 8'h10, 8'h00, 16'd1, 1'b0, 0);
        random_traffic(15);

        set_rooms(8'd255, 16'd65535);
        random_traffic(20);

        // output held off while input keeps coming
        set_rooms(8'd3, 16'd5);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        random_traffic(30);
        no_gaps  = 1'b0;

        set_rooms(8'd8, 16'd255);
        random_traffic(20);

        set_rooms(8'($urandom), 16'($urandom_range(0, 300)));
        random_traffic(20);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (check_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
